### design/rrbb_pkg.sv
// ----------------------------------------------------------------------------
// rrbb_pkg
// Shared types, constants and the CORDIC angle table for the rotated
// rectangle bounding box core.
// ----------------------------------------------------------------------------
package rrbb_pkg;

    localparam int FRAC_BITS_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int HALF_TURN         = 46080;
    localparam int QUARTER_TURN      = 23040;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [33:0] UNIT_Q30    = 34'd1073741824;

    // angle in 2^-20 degree: 90 deg * 2^20 < 2^27, carry sign and headroom
    localparam int ZW = 29;
    // cordic x/y in Q2.30 plus sign and headroom
    localparam int XW = 34;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    function automatic logic signed [ZW-1:0] atan_deg20(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = ZW'(47185920);
            1:  v = ZW'(27855475);
            2:  v = ZW'(14718068);
            3:  v = ZW'(7471121);
            4:  v = ZW'(3750058);
            5:  v = ZW'(1876857);
            6:  v = ZW'(938658);
            7:  v = ZW'(469357);
            8:  v = ZW'(234682);
            9:  v = ZW'(117342);
            10: v = ZW'(58671);
            11: v = ZW'(29335);
            12: v = ZW'(14668);
            13: v = ZW'(7334);
            14: v = ZW'(3667);
            15: v = ZW'(1833);
            16: v = ZW'(917);
            17: v = ZW'(458);
            18: v = ZW'(229);
            19: v = ZW'(115);
            20: v = ZW'(57);
            21: v = ZW'(29);
            22: v = ZW'(14);
            23: v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/rrbb_if.sv
// ----------------------------------------------------------------------------
// rrbb_in_if / rrbb_out_if
// Valid/ready channels carrying one rectangle and one bounding box.
// ----------------------------------------------------------------------------
interface rrbb_in_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  left_pos;
    logic signed [23:0]  top_pos;
    logic signed [23:0]  rect_width;
    logic signed [23:0]  rect_height;
    logic signed [17:0]  rotation;

    modport source (output valid, left_pos, top_pos, rect_width, rect_height,
                    rotation, input ready);
    modport sink   (input valid, left_pos, top_pos, rect_width, rect_height,
                    rotation, output ready);
endinterface

interface rrbb_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  box_left;
    logic signed [15:0]  box_top;
    logic signed [17:0]  box_width;
    logic signed [17:0]  box_height;
    logic                empty_flag;

    modport source (output valid, box_left, box_top, box_width, box_height,
                    empty_flag, input ready);
    modport sink   (input valid, box_left, box_top, box_width, box_height,
                    empty_flag, output ready);
endinterface

### design/rrbb_cordic_cell.sv
// ----------------------------------------------------------------------------
// rrbb_cordic_cell
// One rotation-mode CORDIC micro-rotation with its side-band payload.
// ----------------------------------------------------------------------------
module rrbb_cordic_cell
    import rrbb_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int PW    = 8
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  cordic_vec_t       vec_in,
    input  logic [PW-1:0]     pay_in,
    output logic              vld_out,
    output cordic_vec_t       vec_out,
    output logic [PW-1:0]     pay_out
);

    logic          vld_reg;
    cordic_vec_t   vec_reg, vec_next;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        logic signed [XW-1:0] dx, dy;
        dx = vec_in.y >>> STAGE;
        dy = vec_in.x >>> STAGE;
        if (!vec_in.z[ZW-1])
        begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - atan_deg20(STAGE);
        end
        else
        begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + atan_deg20(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            pay_reg <= pay_in;
        end
    end

    assign vld_out = vld_reg;
    assign vec_out = vec_reg;
    assign pay_out = pay_reg;

endmodule

### design/rotated_rect_bounding_box_core.sv
// ----------------------------------------------------------------------------
// rotated_rect_bounding_box_core
// Axis-aligned bounding box of a rotated rectangle, fully pipelined.
// ----------------------------------------------------------------------------
// Depth: CORDIC_STAGES + 5 register stages.
// Throughput: one transaction per cycle; the pipeline is a chain of CORDIC
//   cells plus fold, multiply, sum and rounding stages, all advancing together.
// Back-pressure stalls the whole chain; input ready follows output ready or
//   an empty output slot.
// Reset: asynchronous, active low; clears every valid bit, no payload reset.
module rotated_rect_bounding_box_core
    import rrbb_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic  clk,
    input  logic  rst_n,
    rrbb_in_if.sink    in_ch,
    rrbb_out_if.source out_ch
);

    localparam int SH = FRAC_BITS + 31;
    // payload carried beside the CORDIC: x,y,w,h,empty,zero-angle
    localparam int PW = 4*24 + 2;

    // Whole pipeline moves when the output slot is free or being drained.
    logic en;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- stage 0: angle fold ----------------
    // |a| mod 180 deg, then mirror above 90 deg. |a| <= 2^17 so at most two
    // subtractions of the half turn are needed.
    logic [17:0] abs_a;
    logic [17:0] r0, r1, r2;
    always_comb
    begin
        abs_a = in_ch.rotation[17] ? 18'(-in_ch.rotation) : in_ch.rotation;
        r0 = abs_a;
        r1 = (r0 >= 18'(HALF_TURN)) ? r0 - 18'(HALF_TURN) : r0;
        r2 = (r1 >= 18'(HALF_TURN)) ? r1 - 18'(HALF_TURN) : r1;
    end

    logic          f_vld_reg;
    logic [16:0]   f_r_reg;
    logic [PW-1:0] f_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_r_reg   <= 17'(r2);
            f_pay_reg <= {in_ch.left_pos, in_ch.top_pos, in_ch.rect_width,
                          in_ch.rect_height,
                          (in_ch.rect_width <= 0) || (in_ch.rect_height <= 0),
                          in_ch.rotation == '0};
        end
    end

    // ---------------- CORDIC chain ----------------
    logic [16:0]  r_fold;
    cordic_vec_t  c_vec [CORDIC_STAGES+1];
    logic         c_vld [CORDIC_STAGES+1];
    logic [PW-1:0] c_pay [CORDIC_STAGES+1];

    assign r_fold = (f_r_reg > 17'(QUARTER_TURN)) ? 17'(HALF_TURN) - f_r_reg : f_r_reg;
    assign c_vec[0].x = XW'(CORDIC_GAIN);
    assign c_vec[0].y = '0;
    assign c_vec[0].z = ZW'({r_fold, 12'd0});
    assign c_vld[0]   = f_vld_reg;
    assign c_pay[0]   = f_pay_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        rrbb_cordic_cell #(.STAGE(g), .PW(PW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (c_vld[g]),
            .vec_in  (c_vec[g]),
            .pay_in  (c_pay[g]),
            .vld_out (c_vld[g+1]),
            .vec_out (c_vec[g+1]),
            .pay_out (c_pay[g+1])
        );
    end

    // ---------------- stage M: clamp and four products ----------------
    logic signed [23:0] px, py, pw, ph;
    logic               p_empty, p_zero;
    assign {px, py, pw, ph, p_empty, p_zero} = c_pay[CORDIC_STAGES];

    logic [30:0] cosv, sinv;
    always_comb
    begin
        logic signed [XW-1:0] cx, sy;
        cx = c_vec[CORDIC_STAGES].x;
        sy = c_vec[CORDIC_STAGES].y;
        cosv = cx[XW-1] ? '0 : (cx > $signed(UNIT_Q30)) ? 31'(UNIT_Q30) : 31'(cx);
        sinv = sy[XW-1] ? '0 : (sy > $signed(UNIT_Q30)) ? 31'(UNIT_Q30) : 31'(sy);
    end

    // 24 x 32 signed products, one multiplier each
    logic          m_vld_reg;
    logic signed [55:0] wc_reg, hs_reg, ws_reg, hc_reg;
    logic signed [23:0] mx_reg, my_reg, mw_reg, mh_reg;
    logic          m_empty_reg, m_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= c_vld[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wc_reg <= pw * $signed({1'b0, cosv});
            hs_reg <= ph * $signed({1'b0, sinv});
            ws_reg <= pw * $signed({1'b0, sinv});
            hc_reg <= ph * $signed({1'b0, cosv});
            mx_reg <= px;
            my_reg <= py;
            mw_reg <= pw;
            mh_reg <= ph;
            m_empty_reg <= p_empty;
            m_zero_reg  <= p_zero;
        end
    end

    // ---------------- stage E: extents and min edges ----------------
    localparam int EW = 60;
    logic signed [EW-1:0] ex_next, ey_next;
    assign ex_next = EW'(wc_reg) + EW'(hs_reg);
    assign ey_next = EW'(ws_reg) + EW'(hc_reg);

    logic          e_vld_reg;
    logic signed [EW-1:0] ex_reg, ey_reg, minx_reg, miny_reg;
    logic signed [23:0] ew_reg, eh_reg, el_reg, et_reg;
    logic          e_empty_reg, e_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= m_vld_reg;
    end

    // centre term is a shift of (2x + w) by 30 bits
    logic signed [EW-1:0] cx_full, cy_full;
    assign cx_full = (EW'(mx_reg) + EW'(mx_reg) + EW'(mw_reg)) <<< 30;
    assign cy_full = (EW'(my_reg) + EW'(my_reg) + EW'(mh_reg)) <<< 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            minx_reg <= cx_full - ex_next;
            miny_reg <= cy_full - ey_next;
            ew_reg <= mw_reg;
            eh_reg <= mh_reg;
            el_reg <= mx_reg;
            et_reg <= my_reg;
            e_empty_reg <= m_empty_reg;
            e_zero_reg  <= m_zero_reg;
        end
    end

    // rounding: truncation toward zero of (v + half) / 2^sh
    function automatic logic signed [EW-1:0] rnd(input logic signed [EW-1:0] v,
                                                 input int sh);
        logic signed [EW-1:0] t, q;
        t = v + (EW'(1) <<< (sh - 1));
        q = t >>> sh;
        if (t[EW-1] && ((t & ((EW'(1) <<< sh) - EW'(1))) != '0))
            q = q + EW'(1);
        return q;
    endfunction

    // ---------------- stage L: round left/top edges ----------------
    logic          l_vld_reg;
    logic signed [EW-1:0] l_reg, t_reg, rx_reg, ry_reg;
    logic signed [EW-1:0] zl_reg, zt_reg, zw_reg, zh_reg;
    logic          l_empty_reg, l_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_vld_reg <= 1'b0;
        else if (en)
            l_vld_reg <= e_vld_reg;
    end

    logic signed [EW-1:0] lq, tq;
    always_comb
    begin
        lq = rnd(minx_reg, SH);
        tq = rnd(miny_reg, SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg  <= lq;
            t_reg  <= tq;
            // residual of the rounded edge plus full extent
            rx_reg <= minx_reg - (lq <<< SH) + (ex_reg <<< 1);
            ry_reg <= miny_reg - (tq <<< SH) + (ey_reg <<< 1);
            zl_reg <= rnd(EW'(el_reg) <<< 1, FRAC_BITS + 1);
            zt_reg <= rnd(EW'(et_reg) <<< 1, FRAC_BITS + 1);
            zw_reg <= rnd(EW'(ew_reg) <<< 1, FRAC_BITS + 1);
            zh_reg <= rnd(EW'(eh_reg) <<< 1, FRAC_BITS + 1);
            l_empty_reg <= e_empty_reg;
            l_zero_reg  <= e_zero_reg;
        end
    end

    // ---------------- stage O: sizes, select, saturate ----------------
    function automatic logic signed [EW-1:0] sat(input logic signed [EW-1:0] v,
                                                 input int bits);
        logic signed [EW-1:0] hi, lo;
        hi = (EW'(1) <<< (bits - 1)) - EW'(1);
        lo = -hi - EW'(1);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    logic signed [EW-1:0] bl, bt, bw, bh;
    always_comb
    begin
        if (l_empty_reg)
        begin
            bl = '0; bt = '0; bw = '0; bh = '0;
        end
        else if (l_zero_reg)
        begin
            bl = zl_reg; bt = zt_reg; bw = zw_reg; bh = zh_reg;
        end
        else
        begin
            bl = l_reg; bt = t_reg;
            bw = rnd(rx_reg, SH);
            bh = rnd(ry_reg, SH);
        end
    end

    logic               o_vld_reg;
    logic signed [15:0] o_l_reg, o_t_reg;
    logic signed [17:0] o_w_reg, o_h_reg;
    logic               o_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= l_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_l_reg <= 16'(sat(bl, 16));
            o_t_reg <= 16'(sat(bt, 16));
            o_w_reg <= 18'(sat(bw, 18));
            o_h_reg <= 18'(sat(bh, 18));
            o_e_reg <= l_empty_reg;
        end
    end

    assign out_ch.valid      = o_vld_reg;
    assign out_ch.box_left   = o_l_reg;
    assign out_ch.box_top    = o_t_reg;
    assign out_ch.box_width  = o_w_reg;
    assign out_ch.box_height = o_h_reg;
    assign out_ch.empty_flag = o_e_reg;

    // ---------------- assertions ----------------
    // Stalled output stays valid and holds its box_left.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.box_left))
        else $error("output changed while stalled");

    // Empty boxes have zero width and height.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.empty_flag |-> out_ch.box_width == '0 &&
        out_ch.box_height == '0)
        else $error("empty box not zero");

    // Ready tracks the free output slot.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with free output");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotated rectangle bounding box core. Rectangles
// are driven over the input channel, a local bit-accurate predictor computes
// the box for each accepted transaction, and a checker compares each output
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import rrbb_pkg::*;

    // predicted box
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [17:0] width;
        logic signed [17:0] height;
        logic               empty;
    } box_t;

    localparam int PRED_FRAC   = 8;
    localparam int PRED_STAGES = 16;
    localparam int LATENCY     = PRED_STAGES + 6;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rrbb_in_if  in_ch ();
    rrbb_out_if out_ch ();

    rotated_rect_bounding_box_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    box_t   box_queue[$];
    int     errors = 0;
    int     boxes_checked = 0;
    int     sent = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    longint cycles = 0;

    // -------------------------------------------------------------------
    // Predictor helpers
    // -------------------------------------------------------------------
    // floor shift of a signed value: arithmetic right shift already floors
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // truncation toward zero of v + 1/2 (SystemVerilog division truncates)
    function automatic longint round_half(longint v, int sh);
        longint one;
        one = longint'(1) << sh;
        return (v + (one >>> 1)) / one;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // rotation-mode CORDIC, angle in 2^-20 degree, result Q2.30 in [0, 1]
    task automatic sincos_q30(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < PRED_STAGES && i < ATAN_ENTRIES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (ang >= 0)
            begin
                x -= dx; y += dy; ang -= longint'(atan_deg20(i));
            end
            else
            begin
                x += dx; y -= dy; ang += longint'(atan_deg20(i));
            end
        end
        c = x < 0 ? 0 : (x > longint'(UNIT_Q30) ? longint'(UNIT_Q30) : x);
        s = y < 0 ? 0 : (y > longint'(UNIT_Q30) ? longint'(UNIT_Q30) : y);
    endtask

    // expected box for one rectangle
    task automatic predict_box(input logic signed [23:0] lp, input logic signed [23:0] tp,
                               input logic signed [23:0] rw, input logic signed [23:0] rh,
                               input logic signed [17:0] rot, output box_t b);
        longint x, y, w, h, a, r, c, s, ex, ey, mx, my, l, t, bl, bt, bw, bh, one;
        int sh;
        x = lp; y = tp; w = rw; h = rh; a = rot;
        sh = PRED_FRAC + 31;
        one = longint'(1) << sh;
        b.empty = 1'b0;
        if (w <= 0 || h <= 0)
        begin
            bl = 0; bt = 0; bw = 0; bh = 0;
            b.empty = 1'b1;
        end
        else if (a == 0)
        begin
            bl = round_half(2 * x, PRED_FRAC + 1);
            bt = round_half(2 * y, PRED_FRAC + 1);
            bw = round_half(2 * w, PRED_FRAC + 1);
            bh = round_half(2 * h, PRED_FRAC + 1);
        end
        else
        begin
            r = (a < 0 ? -a : a) % HALF_TURN;
            if (r > QUARTER_TURN)
                r = HALF_TURN - r;
            sincos_q30(r * 4096, c, s);
            ex = w * c + h * s;
            ey = w * s + h * c;
            mx = (2 * x + w) * longint'(UNIT_Q30) - ex;
            my = (2 * y + h) * longint'(UNIT_Q30) - ey;
            l = round_half(mx, sh);
            t = round_half(my, sh);
            bw = round_half(mx - l * one + 2 * ex, sh);
            bh = round_half(my - t * one + 2 * ey, sh);
            bl = l;
            bt = t;
        end
        b.left   = 16'(clip(bl, 16));
        b.top    = 16'(clip(bt, 16));
        b.width  = 18'(clip(bw, 18));
        b.height = 18'(clip(bh, 18));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH box %0d %s: got %0d expected %0d", boxes_checked, what, got, want);
    endtask

    // -------------------------------------------------------------------
    // Input side: prediction is taken at the accepting edge
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        box_t b;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_box(in_ch.left_pos, in_ch.top_pos, in_ch.rect_width,
                        in_ch.rect_height, in_ch.rotation, b);
            box_queue.push_back(b);
        end
    end

    // -------------------------------------------------------------------
    // Output side: compare each result transaction with the oldest entry
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        box_t b;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (box_queue.size() == 0)
            begin
                errors++;
                $display("UNEXPECTED box transaction with nothing predicted");
            end
            else
            begin
                b = box_queue.pop_front();
                if (out_ch.box_left !== b.left)
                    report_mismatch("box_left", out_ch.box_left, b.left);
                if (out_ch.box_top !== b.top)
                    report_mismatch("box_top", out_ch.box_top, b.top);
                if (out_ch.box_width !== b.width)
                    report_mismatch("box_width", out_ch.box_width, b.width);
                if (out_ch.box_height !== b.height)
                    report_mismatch("box_height", out_ch.box_height, b.height);
                if (out_ch.empty_flag !== b.empty)
                    report_mismatch("empty_flag", out_ch.empty_flag, b.empty);
            end
            boxes_checked++;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d boxes outstanding", cycles,
                     box_queue.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------
    // one rectangle transaction; valid held across back-to-back sends
    task automatic send_rect(input logic [23:0] lp, input logic [23:0] tp,
                             input logic [23:0] rw, input logic [23:0] rh,
                             input logic [17:0] rot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_pos    <= lp;
        in_ch.top_pos     <= tp;
        in_ch.rect_width  <= rw;
        in_ch.rect_height <= rh;
        in_ch.rotation    <= rot;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
    endtask

    // hold off until every predicted box has come back
    task automatic drain();
        drop_valid();
        while (box_queue.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [17:0] rand_angle();
        case ($urandom_range(5))
            0: return 18'($signed($urandom_range(2 * 92160)) - 92160);
            1: return 18'($urandom);               // any pattern of the field
            2: return 18'(256 * ($signed($urandom_range(16)) - 8) * 45);
            3: return 18'($signed($urandom_range(512)) - 256);
            default: return 18'($signed($urandom_range(2 * 23040)) - 23040);
        endcase
    endfunction

    function automatic logic [23:0] rand_pos();
        if ($urandom_range(3) == 0)
            return 24'($urandom);
        return 24'($signed($urandom_range(2 * 2000 * 256)) - 2000 * 256);
    endfunction

    function automatic logic [23:0] rand_size();
        case ($urandom_range(9))
            0: return 24'($urandom);                   // full range, incl. negatives
            1: return 24'($signed($urandom_range(4)) - 2); // around zero
            2: return 24'($urandom_range(24'h7FFFFF, 24'h700000));
            default: return 24'($urandom_range(500 * 256, 1));
        endcase
    endfunction

    task automatic test_directed();
        // empty cases: zero, negative and most negative sizes
        send_rect(24'd256, 24'd256, 24'd0, 24'd512, 18'd0);
        send_rect(24'd256, 24'd256, 24'd512, 24'd0, 18'd1000);
        send_rect(24'd0, 24'd0, 24'h800000, 24'h800000, 18'd0);
        send_rect(24'd0, 24'd0, 24'hFFFFFF, 24'd256, 18'd5);
        // zero angle: rounding of halves, positive and negative
        send_rect(24'd128, 24'hFFFF80, 24'd384, 24'd1, 18'd0);
        send_rect(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 18'd0);
        send_rect(24'h800000, 24'h7FFFFF, 24'd1, 24'd1, 18'd0);
        // quarter, half, full turns, the field extremes, one step and eighth turns
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, 18'd23040);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, 18'd46080);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, -18'sd46080);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, 18'd92160);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, -18'sd92160);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, 18'h1FFFF);
        send_rect(24'd2560, 24'd2560, 24'd5120, 24'd2560, 18'h20000);
        send_rect(24'd0, 24'd0, 24'd256, 24'd256, 18'd1);
        send_rect(24'd0, 24'd0, 24'd256, 24'd256, 18'd11520);
        send_rect(24'd0, 24'd0, 24'd256, 24'd256, -18'sd11520);
        // saturation of edges and sizes
        send_rect(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 18'd11520);
        send_rect(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 18'd30000);
        send_rect(24'h800000, 24'h800000, 24'd1, 24'h7FFFFF, 18'd100);
        drain();
    endtask

    // valid is left as the last send set it; the next send or a drain takes over
    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
            send_rect(rand_pos(), rand_pos(), rand_size(), rand_size(), rand_angle());
    endtask

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.left_pos    = '0;
        in_ch.top_pos     = '0;
        in_ch.rect_width  = '0;
        in_ch.rect_height = '0;
        in_ch.rotation    = '0;
        out_ch.ready      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(500, 0, 0);
        test_random(450, 57, 0);
        drain();                          // sender waits for every box
        test_random(450, 0, 57);
        test_random(500, 31, 31);
        stall_pct = 0;
        drain();
        repeat (LATENCY + 4) @(negedge clk);

        $display("covered %0d rectangles, %0d boxes checked, in %0d cycles", sent,
                 boxes_checked, cycles);
        if (errors == 0 && box_queue.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
design/rrbb_pkg.sv
design/rrbb_if.sv
design/rrbb_cordic_cell.sv
design/rotated_rect_bounding_box_core.sv
bench/tb_top.sv
